// File: hdl/vgf_pkg.sv
// shared constants, types and hash function for the voxel grid filter
package vgf_pkg;

  localparam int COORD_W = 32;
  localparam int SCALE_W = 26;
  localparam int KEY_W = 32;
  localparam int SEED_W = 32;
  localparam int PROD_SHIFT = 32;

  localparam logic [SEED_W-1:0] HASH_GOLDEN = 32'h9e3779b9;
  localparam int HASH_LSHIFT = 6;
  localparam int HASH_RSHIFT = 2;

  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FREE = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

  localparam int DEF_TABLE_DEPTH = 4096;
  localparam int DEF_MAX_PROBES = 8;

  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_VOXEL_SCALE = 2'd0;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 26'd655360;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_HASH,
    ST_MOD,
    ST_PROBE_RD,
    ST_PROBE_CK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [KEY_W-1:0]   key_x;
    logic [KEY_W-1:0]   key_y;
    logic [KEY_W-1:0]   key_z;
  } entry_t;

  // hash-combine step
  function automatic logic [SEED_W-1:0] hash_mix(input logic [SEED_W-1:0] seed,
                                                 input logic [KEY_W-1:0] key);
    return seed ^ (key + HASH_GOLDEN + (seed << HASH_LSHIFT) + (seed >> HASH_RSHIFT));
  endfunction

endpackage

// File: hdl/vgf_stream_if.sv
// stream interfaces for input points and kept points
interface vgf_point_if import vgf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic                      point_ok;
  logic                      frame_start;

  modport source (output valid, point_x, point_y, point_z, point_ok, frame_start,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, point_ok, frame_start,
                output ready);
endinterface

interface vgf_kept_if import vgf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] kept_x;
  logic signed [COORD_W-1:0] kept_y;
  logic signed [COORD_W-1:0] kept_z;
  logic                      table_overflow;

  modport source (output valid, kept_x, kept_y, kept_z, table_overflow, input ready);
  modport sink (input valid, kept_x, kept_y, kept_z, table_overflow, output ready);
endinterface

// File: hdl/vgf_slot_mod.sv
// reduces the hash seed to a home slot, modulo the table depth
module vgf_slot_mod import vgf_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [SEED_W-1:0]              seed,
  output logic                           done,
  output logic [$clog2(TABLE_DEPTH)-1:0] slot
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam int RECIP_W = SEED_W + 1;
  localparam int RECIP_SHIFT = SEED_W + IDX_W;
  // ceil(2^(SEED_W+IDX_W) / depth) gives the exact quotient for every 32-bit seed
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));
  localparam logic [SEED_W-1:0] DEPTH_SEED = SEED_W'(TABLE_DEPTH);

  logic                      mul_busy;
  logic                      sub_busy;
  logic [SEED_W-1:0]         seed_q;
  logic [SEED_W-1:0]         quot;
  logic [SEED_W+RECIP_W-1:0] recip_prod;
  logic [SEED_W-1:0]         back_prod;
  logic [SEED_W-1:0]         rem_full;

  // quotient by reciprocal multiply, then remainder by multiply back and subtract
  assign recip_prod = seed_q * RECIP;
  assign back_prod  = quot * DEPTH_SEED;
  assign rem_full   = seed_q - back_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      sub_busy <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (IS_POW2) begin
          slot <= seed[IDX_W-1:0];
          done <= 1'b1;
        end else begin
          mul_busy <= 1'b1;
          seed_q   <= seed;
        end
      end else if (mul_busy) begin
        mul_busy <= 1'b0;
        sub_busy <= 1'b1;
        quot     <= SEED_W'(recip_prod >> RECIP_SHIFT);
      end else if (sub_busy) begin
        sub_busy <= 1'b0;
        done     <= 1'b1;
        slot     <= rem_full[IDX_W-1:0];
      end
    end
  end

endmodule

// File: hdl/voxel_grid_first_point_filter.sv
// Voxel grid first-point filter: passes a lidar point only when its voxel is new in the frame,
// or flagged by table_overflow when none of the probed slots is free or holds its voxel.
// An accepted point with point_ok set goes through a key multiply, a hash combine per axis,
// the slot reduction (a reciprocal multiply, then a multiply back and subtract, when
// TABLE_DEPTH is not a power of two), a read and a check per probe (1 to MAX_PROBES) on
// the slot table, and a hand-over of a kept point to the output register, which waits while
// the previous kept point is still there. A point whose voxel is already in the table ends
// without a result. A point with point_ok clear yields no result. Frame start is an epoch
// change; in addition, every 255th frame start and the time after reset run a clearing pass
// over the slot table, during which no point is accepted.
// Configuration writes are taken at any time.
module voxel_grid_first_point_filter import vgf_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int MAX_PROBES  = DEF_MAX_PROBES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  vgf_point_if.sink             points,
  vgf_kept_if.source            kept
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int PRB_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [PRB_W-1:0] PROBE_LAST = PRB_W'(MAX_PROBES - 1);
  localparam logic [1:0] AXIS_LAST = 2'd2;

  state_t state, state_next;

  logic [SCALE_W-1:0] voxel_scale;
  logic [EPOCH_W-1:0] epoch;
  logic               pend;
  logic [IDX_W-1:0]   clr_addr;
  logic               out_valid;

  logic signed [COORD_W-1:0] px, py, pz;
  logic [KEY_W-1:0]          kx, ky, kz;
  logic [SEED_W-1:0]         seed;
  logic [1:0]                axis;
  logic [IDX_W-1:0]          slot;
  logic [PRB_W-1:0]          probe;
  logic                      ovf;

  logic signed [COORD_W-1:0] out_x, out_y, out_z;
  logic                      out_ovf;

  entry_t             table_mem [TABLE_DEPTH];
  entry_t             rd_entry;
  logic               mem_we;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;

  logic               accept;
  logic               out_load;
  logic               mod_start;
  logic               mod_done;
  logic [IDX_W-1:0]   mod_slot;

  logic signed [COORD_W+SCALE_W:0] prod_x, prod_y, prod_z;
  logic [KEY_W-1:0]   hash_key;
  logic [SEED_W-1:0]  hash_in;
  logic [SEED_W-1:0]  mix_out;
  logic               slot_free;
  logic               key_hit;
  logic [IDX_W-1:0]   slot_inc;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_VOXEL_SCALE) ? APB_DATA_W'(voxel_scale) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      voxel_scale <= SCALE_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_VOXEL_SCALE) begin
      voxel_scale <= pwdata[SCALE_W-1:0];
    end
  end

  // voxel keys: floor(coord * scale / 2^32), the arithmetic shift gives the floor
  assign prod_x = px * $signed({1'b0, voxel_scale});
  assign prod_y = py * $signed({1'b0, voxel_scale});
  assign prod_z = pz * $signed({1'b0, voxel_scale});

  always_comb begin
    case (axis)
      2'd0:    hash_key = kx;
      2'd1:    hash_key = ky;
      default: hash_key = kz;
    endcase
  end

  assign hash_in = (axis == 2'd0) ? '0 : seed;
  assign mix_out = hash_mix(hash_in, hash_key);

  vgf_slot_mod #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_slot_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .seed  (mix_out),
    .done  (mod_done),
    .slot  (mod_slot)
  );

  // slot table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_entry <= table_mem[slot];
    end
  end

  // an entry from an older epoch counts as empty
  assign slot_free = rd_entry.epoch != epoch;
  assign key_hit = rd_entry.key_x == kx && rd_entry.key_y == ky && rd_entry.key_z == kz;
  assign slot_inc = (slot == SLOT_LAST) ? '0 : slot + 1'b1;

  assign points.ready = (state == ST_IDLE);
  assign accept = points.valid && points.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = slot;
    mem_wdata  = '{epoch: epoch, key_x: kx, key_y: ky, key_z: kz};
    mod_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '{epoch: EPOCH_FREE, key_x: '0, key_y: '0, key_z: '0};
        if (clr_addr == SLOT_LAST) begin
          state_next = pend ? ST_MUL : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (points.frame_start && epoch == EPOCH_LAST) begin
            state_next = ST_CLEAR;
          end else if (points.point_ok) begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_next = ST_HASH;
      end
      ST_HASH: begin
        if (axis == AXIS_LAST) begin
          mod_start  = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_next = ST_PROBE_RD;
        end
      end
      ST_PROBE_RD: begin
        mem_re     = 1'b1;
        state_next = ST_PROBE_CK;
      end
      ST_PROBE_CK: begin
        if (slot_free) begin
          mem_we     = 1'b1;
          state_next = ST_EMIT;
        end else if (key_hit) begin
          state_next = ST_IDLE;
        end else if (probe == PROBE_LAST) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PROBE_RD;
        end
      end
      ST_EMIT: begin
        if (!out_valid || kept.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch     <= EPOCH_FIRST;
      pend      <= 1'b0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == SLOT_LAST) begin
          epoch <= EPOCH_FIRST;
        end
      end else begin
        clr_addr <= '0;
      end
      if (accept) begin
        pend <= points.point_ok;
        if (points.frame_start && epoch != EPOCH_LAST) begin
          epoch <= epoch + 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (kept.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px <= points.point_x;
      py <= points.point_y;
      pz <= points.point_z;
    end
    case (state)
      ST_MUL: begin
        kx   <= KEY_W'(prod_x >>> PROD_SHIFT);
        ky   <= KEY_W'(prod_y >>> PROD_SHIFT);
        kz   <= KEY_W'(prod_z >>> PROD_SHIFT);
        axis <= '0;
      end
      ST_HASH: begin
        seed <= mix_out;
        axis <= axis + 1'b1;
      end
      ST_MOD: begin
        if (mod_done) begin
          slot  <= mod_slot;
          probe <= '0;
        end
      end
      ST_PROBE_CK: begin
        if (slot_free) begin
          ovf <= 1'b0;
        end else if (probe == PROBE_LAST) begin
          ovf <= 1'b1;
        end else begin
          probe <= probe + 1'b1;
          slot  <= slot_inc;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_x   <= px;
      out_y   <= py;
      out_z   <= pz;
      out_ovf <= ovf;
    end
  end

  assign kept.valid          = out_valid;
  assign kept.kept_x         = out_x;
  assign kept.kept_y         = out_y;
  assign kept.kept_z         = out_z;
  assign kept.table_overflow = out_ovf;

endmodule
